@@ src/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix converter package
// Item types, base limits and widths shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  // Fixed field widths
  localparam int unsigned NumberW = 64;
  localparam int unsigned BaseW   = 4;
  localparam int unsigned DigitW  = 4;

  // Accepted radix range
  localparam logic [BaseW-1:0] MinBase = 4'd2;
  localparam logic [BaseW-1:0] MaxBase = 4'd10;

  // Bits of the value consumed per divider cycle
  localparam int unsigned ChunkW = 8;

  // Request item
  typedef struct packed {
    logic [NumberW-1:0] number;
    logic [BaseW-1:0]   from_base;
    logic [BaseW-1:0]   to_base;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              last;
    logic              error;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [NumberW-1:0] number;
    logic [BaseW-1:0]   from_base;
    logic [BaseW-1:0]   to_base;
    logic               bad_base;
  } job_t;

endpackage

`default_nettype wire

@@ src/radix_converter_base2_to_10_core.sv @@
// ----------------------------------------------------------------------------
// Radix converter core
// Converts a decimal-digit string read in a source radix to target-radix digits.
// ----------------------------------------------------------------------------
// Flow: the front register and the queue, then BCD decode of the number bits,
//   accumulation of the decimal digits, the divider once per output digit,
//   then per emitted digit a digit store read and an output load.
// The back end holds one request at a time; the divider runs a chunk per step.
// Reset: asynchronous, active low; clears control, leaves the digit store as is.
`default_nettype none

module radix_converter_base2_to_10_core #(
  parameter int unsigned NUMBER_BITS    = 64,
  parameter int unsigned MAX_OUT_DIGITS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rbc_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rbc_pkg::out_item_t     out_item_o
);
  import rbc_pkg::*;

  logic front_valid, front_ready;
  job_t front_job;
  logic back_valid, back_ready;
  job_t back_job;

  // Accept and classify
  rbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  // Decouple front and back
  rbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_job_o    (back_job)
  );

  // Convert and emit
  rbc_back #(
    .NUMBER_BITS    (NUMBER_BITS),
    .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // An error result is a lone zero digit that closes its request
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error |-> out_item_o.last && (out_item_o.digit == '0))
    else $error("error result not a single closing zero digit");

  // Every emitted digit is below the largest supported radix
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.digit < MaxBase))
    else $error("emitted digit out of range");

endmodule

`default_nettype wire

@@ src/rbc_front.sv @@
// ----------------------------------------------------------------------------
// Radix converter front end
// Accepts request items, checks both radixes and registers the classified job.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rbc_pkg::in_item_t in_item_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output rbc_pkg::job_t         job_o
);
  import rbc_pkg::*;

  logic job_valid_q, job_valid_d;
  job_t job_q, job_d;
  logic accept;
  logic from_bad, to_bad;

  // Flag a radix outside the supported range
  assign from_bad = (in_item_i.from_base < MinBase) || (in_item_i.from_base > MaxBase);
  assign to_bad   = (in_item_i.to_base < MinBase) || (in_item_i.to_base > MaxBase);

  // Take a new item when the stage is empty or drains this cycle
  assign in_ready_o = !job_valid_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    if (accept) begin
      job_d.number    = in_item_i.number;
      job_d.from_base = in_item_i.from_base;
      job_d.to_base   = in_item_i.to_base;
      job_d.bad_base  = from_bad || to_bad;
      job_valid_d     = 1'b1;
    end else if (job_ready_i) begin
      job_valid_d = 1'b0;
    end
  end

  // Hold the classified job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_q       <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      job_q       <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

@@ src/rbc_queue.sv @@
// ----------------------------------------------------------------------------
// Radix converter job queue
// Two-entry queue that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire rbc_pkg::job_t push_job_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output rbc_pkg::job_t      pop_job_o
);
  import rbc_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  job_t             entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             push, pop;

  assign push_ready_o = (fill_q != FillW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/rbc_back.sv @@
// ----------------------------------------------------------------------------
// Radix converter back end
// Decodes the decimal digit string, accumulates the source-radix value,
// divides it down by the target radix and emits digits most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_back #(
  parameter int unsigned NUMBER_BITS    = 64,
  parameter int unsigned MAX_OUT_DIGITS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire rbc_pkg::job_t job_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rbc_pkg::out_item_t out_item_o
);
  import rbc_pkg::*;

  // Decimal digits needed for a NUMBER_BITS wide value
  localparam int unsigned DecDigits = (NUMBER_BITS * 30103) / 100000 + 1;
  localparam int unsigned BcdW      = DecDigits * DigitW;
  localparam int unsigned Chunks    = (NUMBER_BITS + ChunkW - 1) / ChunkW;
  localparam int unsigned DivW      = Chunks * ChunkW;
  localparam int unsigned StepW     = $clog2(NUMBER_BITS);
  localparam int unsigned IdxW      = $clog2(MAX_OUT_DIGITS);
  localparam int unsigned CntW      = $clog2(MAX_OUT_DIGITS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StDabble,
    StAccum,
    StDivide,
    StEmitRd,
    StEmitWr,
    StErr
  } state_e;

  state_e                 state_q, state_d;
  logic [NUMBER_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [NUMBER_BITS-1:0] acc_q, acc_d;
  logic                   bad_q, bad_d;
  logic [DivW-1:0]        div_q, div_d;
  logic [DigitW-1:0]      rem_q, rem_d;
  logic [BaseW-1:0]       src_q, src_d;
  logic [BaseW-1:0]       dst_q, dst_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [DigitW-1:0]      store_mem [MAX_OUT_DIGITS];
  logic [DigitW-1:0]      rdata_q;
  logic                   wr_en, rd_en;

  logic [BcdW-1:0]          bcd_adj;
  logic [DigitW-1:0]        top_digit;
  logic [NUMBER_BITS+3:0]   prod;
  logic [NUMBER_BITS-1:0]   acc_next;
  logic [DivW-1:0]          div_next;
  logic [DigitW-1:0]        rem_next;
  logic                     out_free;

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= 4'd5) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  // Horner step: value times source radix plus next digit
  assign top_digit = bcd_q[BcdW-1 -: DigitW];
  assign prod      = {4'b0, acc_q} * {{NUMBER_BITS{1'b0}}, src_q};
  assign acc_next  = prod[NUMBER_BITS-1:0] + NUMBER_BITS'(top_digit);

  // Long division of one chunk by the target radix, a bit per step
  always_comb begin
    logic [DigitW:0]   r;
    logic [ChunkW-1:0] chunk;
    logic [ChunkW-1:0] qbits;
    r     = {1'b0, rem_q};
    chunk = div_q[DivW-1 -: ChunkW];
    qbits = '0;
    for (int b = ChunkW - 1; b >= 0; b--) begin
      r = {r[DigitW-1:0], chunk[b]};
      if (r >= {1'b0, dst_q}) begin
        r        = r - {1'b0, dst_q};
        qbits[b] = 1'b1;
      end
    end
    rem_next = r[DigitW-1:0];
    div_next = {div_q[DivW-ChunkW-1:0], qbits};
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_en    = (state_q == StEmitRd);

  // Sequence one job through decode, accumulate, divide and emit
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    acc_d       = acc_q;
    bad_d       = bad_q;
    div_d       = div_q;
    rem_d       = rem_q;
    src_d       = src_q;
    dst_d       = dst_q;
    step_d      = step_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    wr_en       = 1'b0;
    job_ready_o = (state_q == StIdle);

    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          src_d  = job_i.from_base;
          dst_d  = job_i.to_base;
          bin_d  = job_i.number[NUMBER_BITS-1:0];
          bcd_d  = '0;
          step_d = '0;
          state_d = job_i.bad_base ? StErr : StDabble;
        end
      end
      StDabble: begin
        bcd_d  = {bcd_adj[BcdW-2:0], bin_q[NUMBER_BITS-1]};
        bin_d  = {bin_q[NUMBER_BITS-2:0], 1'b0};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(NUMBER_BITS - 1)) begin
          step_d  = '0;
          acc_d   = '0;
          bad_d   = 1'b0;
          state_d = StAccum;
        end
      end
      StAccum: begin
        acc_d  = acc_next;
        bad_d  = bad_q || (top_digit >= src_q);
        bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DecDigits - 1)) begin
          step_d  = '0;
          div_d   = DivW'(acc_next);
          rem_d   = '0;
          count_d = '0;
          state_d = bad_d ? StErr : StDivide;
        end
      end
      StDivide: begin
        div_d  = div_next;
        rem_d  = rem_next;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(Chunks - 1)) begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
          rem_d   = '0;
          step_d  = '0;
          if ((div_next == '0) || (count_d == CntW'(MAX_OUT_DIGITS))) begin
            rd_idx_d = count_q[IdxW-1:0];
            state_d  = StEmitRd;
          end
        end
      end
      StEmitRd: begin
        state_d = StEmitWr;
      end
      StEmitWr: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d.digit = rdata_q;
          out_item_d.last  = (rd_idx_q == '0);
          out_item_d.error = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = StIdle;
          end else begin
            rd_idx_d = rd_idx_q - IdxW'(1);
            state_d  = StEmitRd;
          end
        end
      end
      StErr: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d.digit = '0;
          out_item_d.last  = 1'b1;
          out_item_d.error = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, datapath and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bin_q       <= '0;
      bcd_q       <= '0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      bcd_q       <= bcd_d;
      acc_q       <= acc_d;
      bad_q       <= bad_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      step_q      <= step_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  // Digit store: least significant digit at index zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[count_q[IdxW-1:0]] <= rem_next;
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ tb/rbc_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix converter result checker
// Watches both channels of the converter core. Each accepted request is
// converted here into the digit items it should produce, and each accepted
// result item is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------

module rbc_result_checker #(
  parameter int unsigned NUMBER_BITS    = 64,
  parameter int unsigned MAX_OUT_DIGITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  rbc_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  rbc_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 expected_left_o
);

  import rbc_pkg::*;

  // Digit items still owed by the core, oldest first
  out_item_t digit_queue[$];
  int        mismatches = 0;
  int        owed_items = 0;

  assign fail_count_o    = mismatches;
  assign expected_left_o = owed_items;

  // Count a mismatch; keep the log short if the core is badly off
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // Queue the digits one request should produce
  function automatic void convert_request(input in_item_t req);
    logic [63:0] num;
    logic [63:0] value;
    logic [63:0] weight;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [3:0]  d;
    logic [3:0]  low_first[$];
    bit          bad;
    int unsigned limit;
    out_item_t   res;
    num   = req.number & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUMBER_BITS));
    src   = req.from_base;
    dst   = req.to_base;
    limit = (MAX_OUT_DIGITS > 64) ? 64 : MAX_OUT_DIGITS;
    res   = '0;
    // Bad radix on either side: one error item
    if (src < MinBase || src > MaxBase || dst < MinBase || dst > MaxBase) begin
      res.last  = 1'b1;
      res.error = 1'b1;
      digit_queue.push_back(res);
      return;
    end
    // Read the decimal digits as source-radix digits, low digit first
    value  = '0;
    weight = 64'd1;
    bad    = 1'b0;
    while (num != 0) begin
      d = 4'(num % 64'd10);
      if (d >= src) begin
        bad = 1'b1;
      end
      value  = value + 64'(d) * weight;
      weight = weight * 64'(src);
      num    = num / 64'd10;
    end
    // Digit not below the source radix: one error item
    if (bad) begin
      res.last  = 1'b1;
      res.error = 1'b1;
      digit_queue.push_back(res);
      return;
    end
    // Divide down; zero still yields one digit
    do begin
      if (low_first.size() < limit) begin
        low_first.push_back(4'(value % 64'(dst)));
      end
      value = value / 64'(dst);
    end while (value != 0 && low_first.size() < limit);
    // Hand out most significant first, flag the final one
    for (int k = low_first.size() - 1; k >= 0; k--) begin
      res.digit = low_first[k];
      res.last  = (k == 0);
      res.error = 1'b0;
      digit_queue.push_back(res);
    end
  endfunction

  // Predict on request items, compare on result items
  always @(posedge clk_i) begin : watch_channels
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        convert_request(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (digit_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected item digit=%0d last=%0b error=%0b",
                                    out_item_i.digit, out_item_i.last, out_item_i.error));
        end else begin
          want = digit_queue.pop_front();
          if (out_item_i.digit !== want.digit) begin
            report_mismatch($sformatf("digit %0d, want %0d", out_item_i.digit, want.digit));
          end
          if (out_item_i.last !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b", out_item_i.last, want.last));
          end
          if (out_item_i.error !== want.error) begin
            report_mismatch($sformatf("error %0b, want %0b", out_item_i.error, want.error));
          end
        end
      end
      owed_items <= digit_queue.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix converter core testbench
// Drives conversion requests with random gaps and pulls digit items with
// random stalls; a separate checker predicts and compares every item.
// Directed corner requests come first, then mostly well-formed random ones.
// ----------------------------------------------------------------------------

module testbench;

  import rbc_pkg::*;

  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned TailCycles  = 1000;
  localparam int unsigned RandomItems = 80;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int expected_left;

  bit no_idle      = 1'b0;
  int n_sent       = 0;
  int n_directed   = 0;
  int n_broken     = 0;
  int n_results    = 0;
  int run_len      = 0;
  int longest_run  = 0;
  int idle_cycles  = 0;

  radix_converter_base2_to_10_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  rbc_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_item_i      (out_item),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hold off a random gap, then offer one request until it is taken
  task automatic send_request(input logic [63:0] num, input logic [3:0] fb,
                              input logic [3:0] tb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item.number    <= num;
    in_item.from_base <= fb;
    in_item.to_base   <= tb;
    in_valid          <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  // Drop valid and wait until every owed digit item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_left != 0);
  endtask

  // Result side: random stall per item, then take it
  initial begin : pull_results
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Watchdog and run statistics
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (out_item.last) begin
          if (run_len + 1 > longest_run) begin
            longest_run <= run_len + 1;
          end
          run_len <= 0;
        end else begin
          run_len <= run_len + 1;
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no item moved for %0d cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int          kind;
    int          ndig;
    int          bad_pos;
    logic [63:0] num;
    logic [3:0]  fb;
    logic [3:0]  tb;
    logic [3:0]  d;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero number, both directions
    send_request(64'd0, 4'd10, 4'd2);
    send_request(64'd0, 4'd2, 4'd10);
    // Widest value: 64 binary digits, and full decimal
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd10, 4'd2);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd10, 4'd10);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd10, 4'd9);
    send_request(64'd1, 4'd2, 4'd2);
    send_request(64'd1111111111111111111, 4'd2, 4'd10);
    send_request(64'd7777777777777777777, 4'd8, 4'd2);
    send_request(64'd8888888888888888888, 4'd9, 4'd3);
    send_request(64'd9999999999999999999, 4'd10, 4'd2);
    send_request(64'd10, 4'd10, 4'd9);
    send_request(64'd1000000, 4'd2, 4'd2);
    // Source radix out of range
    send_request(64'd12345, 4'd0, 4'd10);
    send_request(64'd12345, 4'd1, 4'd10);
    send_request(64'd12345, 4'd11, 4'd10);
    send_request(64'd12345, 4'd15, 4'd10);
    // Target radix out of range
    send_request(64'd12345, 4'd10, 4'd0);
    send_request(64'd12345, 4'd10, 4'd1);
    send_request(64'd12345, 4'd10, 4'd11);
    send_request(64'd12345, 4'd10, 4'd15);
    send_request(64'd0, 4'd15, 4'd15);
    // Digit not below the source radix, low, single and high position
    send_request(64'd2, 4'd2, 4'd10);
    send_request(64'd19, 4'd9, 4'd10);
    send_request(64'd9000000000000000000, 4'd9, 4'd10);
    n_directed = n_sent;
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      // A stretch with no idling on either side
      no_idle = (i >= 30 && i < 50);
      // Let the core run dry once before the last random requests
      if (i == 70) begin
        drain_results();
      end
      kind = $urandom_range(0, 99);
      fb   = 4'($urandom_range(2, 10));
      tb   = 4'($urandom_range(2, 10));
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 19) : $urandom_range(1, 8);
      bad_pos = (kind >= 75 && kind < 88) ? $urandom_range(0, ndig - 1) : -1;
      num  = '0;
      for (int j = 0; j < ndig; j++) begin
        d = 4'($urandom_range(0, fb - 1));
        if (j == bad_pos && fb < 10) begin
          d = 4'($urandom_range(fb, 9));
        end
        num = num * 64'd10 + 64'(d);
      end
      if (bad_pos >= 0) begin
        n_broken++;
        if (fb == 10) begin
          fb = 4'($urandom_range(11, 15));
        end
      end
      // Raw noise: any 64-bit value; either any radix code, or read in radix 10
      if (kind >= 88) begin
        num = {$urandom, $urandom};
        if (kind >= 94) begin
          fb = 4'd10;
        end else begin
          fb = 4'($urandom_range(0, 15));
          tb = 4'($urandom_range(0, 15));
        end
      end
      send_request(num, fb, tb);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Summary: %0d requests (%0d directed, %0d random malformed), %0d digit items",
             n_sent, n_directed, n_broken, n_results);
    $display("Summary: longest digit run %0d, %0d mismatches", longest_run, fail_count);
    if (fail_count == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
